// ===== rtl/core/csl_pkg.sv =====
// Shared types, codes and byte classifiers for the C subset lexer.
`timescale 1ns / 1ps

package csl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_IDENT = 3'd2,
        MODE_PUNCT = 3'd3,
        MODE_ERR   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_NUM   = 3'd0,
        KIND_PUNCT = 3'd1,
        KIND_IDENT = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERR   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    // Up to two tokens leave the scanner per consumed beat; slot a comes first.
    typedef struct packed {
        logic   a_valid;
        t_token a;
        logic   b_valid;
        t_token b;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == 8'h3D) || (c == 8'h3B) || (c == 8'h3E) || (c == 8'h3C) ||
               (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
               (c == 8'h2C) || (c == 8'h26) || (c == 8'h3A);
    endfunction

    // Two-byte operators: <= >= += -= ++ --
    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        return (((a == 8'h3C) || (a == 8'h3E)) && (b == 8'h3D)) ||
               ((a == 8'h2B) && ((b == 8'h3D) || (b == 8'h2B))) ||
               ((a == 8'h2D) && ((b == 8'h3D) || (b == 8'h2D)));
    endfunction

endpackage

// ===== rtl/core/c_subset_lexer.sv =====
// A byte beat is held in the input register, and its tokens pass through the result queue to the output.
// Throughput: one byte per cycle while the result queue has room for two tokens; a beat
// can produce two tokens, so a consumer draining one token per cycle sets the ceiling.
// Reset is synchronous and active low: scan state, offsets, the input register and the
// result queue are cleared, and the block takes a byte in the first cycle after release.
`timescale 1ns / 1ps

module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int TEXT_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_char_byte,
    input  logic        i_is_end,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_text,
    input  logic        i_out_stall
);

    // The scanner holds one byte beat in its input register and retires it in the
    // cycle the queue has room; its state machine follows the runs of numbers,
    // identifiers and held punctuators, flushing the pending token when a run ends.
    t_push  push;
    logic   room;
    t_token head;

    csl_scan #(
        .TEXT_BYTES(TEXT_BYTES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_char_byte(i_char_byte),
        .i_is_end   (i_is_end),
        .o_in_stall (o_in_stall),
        .i_room     (room),
        .o_push     (push)
    );

    // The queue parts the two sides, so a stalled output never stops the scanner
    // until the queue no longer has room for two tokens.
    csl_tokq u_tokq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_out_valid),
        .o_head (head),
        .i_stall(i_out_stall)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_text = head.last;

endmodule

// ===== rtl/core/csl_scan.sv =====
// Input register and per-byte scanner state machine of the C subset lexer.
`timescale 1ns / 1ps

module csl_scan
    import csl_pkg::*;
#(
    parameter int TEXT_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_char_byte,
    input  logic        i_is_end,
    output logic        o_in_stall,
    input  logic        i_room,
    output t_push       o_push
);

    localparam int          CAP_INT = (TEXT_BYTES - 1 > 65535) ? 65535 : TEXT_BYTES - 1;
    localparam logic [15:0] POS_CAP = 16'(CAP_INT);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_end;

    t_mode       r_mode,  n_mode;
    logic [15:0] r_start, n_start;
    logic [15:0] r_pos,   n_pos;
    logic [7:0]  r_held,  n_held;

    logic        consume;
    logic        accept;
    logic [15:0] pos_adv;
    logic [15:0] run_len;
    logic        flush_valid;
    t_token      flush_tok;
    logic        cont;

    assign consume    = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_char_byte;
            r_end  <= i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_held  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_held  <= n_held;
        end
    end

    assign pos_adv = (r_pos < POS_CAP) ? r_pos + 16'd1 : r_pos;
    assign run_len = (r_pos > r_start) ? r_pos - r_start : 16'd1;
    assign cont    = ((r_mode == MODE_NUM) && is_digit(r_byte)) ||
                     ((r_mode == MODE_IDENT) &&
                      (is_lower(r_byte) || is_digit(r_byte) || (r_byte == 8'h5F)));

    // The token that is pending when a run is closed.
    always_comb begin
        flush_valid      = 1'b0;
        flush_tok.kind   = KIND_NUM;
        flush_tok.start  = r_start;
        flush_tok.length = run_len;
        flush_tok.last   = 1'b0;
        unique case (r_mode)
            MODE_NUM: begin
                flush_valid = 1'b1;
            end
            MODE_IDENT: begin
                flush_valid    = 1'b1;
                flush_tok.kind = KIND_IDENT;
            end
            MODE_PUNCT: begin
                flush_valid      = 1'b1;
                flush_tok.kind   = KIND_PUNCT;
                flush_tok.length = 16'd1;
            end
            default: begin
                flush_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_pos    = r_pos;
        n_held   = r_held;
        o_push   = '0;
        o_push.a = flush_tok;
        o_push.b.kind   = KIND_END;
        o_push.b.start  = r_pos;
        o_push.b.length = 16'd0;
        o_push.b.last   = 1'b1;

        if (consume) begin
            if (r_end) begin
                if (r_mode != MODE_ERR) begin
                    o_push.a_valid = flush_valid;
                    o_push.b_valid = 1'b1;
                end
                n_mode  = MODE_IDLE;
                n_start = '0;
                n_pos   = '0;
                n_held  = '0;
            end else if (r_mode != MODE_ERR) begin
                if (cont) begin
                    n_pos = pos_adv;
                end else if ((r_mode == MODE_PUNCT) && is_pair(r_held, r_byte)) begin
                    o_push.a_valid  = 1'b1;
                    o_push.a.kind   = KIND_PUNCT;
                    o_push.a.length = 16'd2;
                    n_mode = MODE_IDLE;
                    n_pos  = pos_adv;
                end else begin
                    o_push.a_valid = flush_valid;
                    n_mode = MODE_IDLE;
                    priority if (is_space(r_byte)) begin
                        n_pos = pos_adv;
                    end else if (is_digit(r_byte)) begin
                        n_mode  = MODE_NUM;
                        n_start = r_pos;
                        n_pos   = pos_adv;
                    end else if (is_lower(r_byte)) begin
                        n_mode  = MODE_IDENT;
                        n_start = r_pos;
                        n_pos   = pos_adv;
                    end else if (is_punct(r_byte)) begin
                        n_mode  = MODE_PUNCT;
                        n_start = r_pos;
                        n_held  = r_byte;
                        n_pos   = pos_adv;
                    end else begin
                        o_push.b_valid  = 1'b1;
                        o_push.b.kind   = KIND_ERR;
                        o_push.b.length = 16'd1;
                        n_mode = MODE_ERR;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/csl_tokq.sv =====
// Four-entry result queue that takes up to two tokens per cycle.
`timescale 1ns / 1ps

module csl_tokq
    import csl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_head,
    input  logic   i_stall
);

    t_token     r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;
    logic [2:0] push_n;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && !i_stall;
    assign push_n  = {2'b00, i_push.a_valid} + {2'b00, i_push.b_valid};
    assign n_count = r_count + push_n - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
            if (i_push.b_valid) begin
                r_mem[r_wr_ptr + 2'd1] <= i_push.b;
            end
        end else if (i_push.b_valid) begin
            r_mem[r_wr_ptr] <= i_push.b;
        end
    end

endmodule

// ===== rtl/core/csl_checker.sv =====
// Port-level checker for the C subset lexer and its bind.
`timescale 1ns / 1ps

module csl_checker
    import csl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic [7:0]  i_char_byte,
    input logic        i_is_end,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic [2:0]  o_token_kind,
    input logic [15:0] o_token_start,
    input logic [15:0] o_token_length,
    input logic        o_last_of_text,
    input logic        i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_start))
        else $error("stalled token beat dropped or changed");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_of_text ==
            ((o_token_kind == KIND_END) || (o_token_kind == KIND_ERR))))
        else $error("last_of_text disagrees with token kind");

    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == KIND_END) |-> (o_token_length == 16'd0))
        else $error("end-of-text token with nonzero length");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_token_kind == KIND_PUNCT) || (o_token_kind == KIND_ERR)) |->
            ((o_token_length == 16'd1) || (o_token_length == 16'd2)))
        else $error("punctuator or error token with bad length");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);
